// ===== hdl/rnf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and digit encoding for the radix number formatter.
// No dependencies.
package rnf_pkg;

    localparam int INT_BITS        = 32;
    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 5;

    localparam int RADIX_W = 6;
    localparam int FCNT_W  = 3;
    localparam int CHAR_W  = 7;
    localparam int CNT_W   = $clog2(INT_BITS);
    localparam int SP_W    = $clog2(INT_BITS + 1);

    localparam logic [RADIX_W-1:0] LOW_RADIX     = 6'd2;
    localparam logic [RADIX_W-1:0] HIGH_RADIX    = 6'd36;
    localparam logic [RADIX_W-1:0] LAST_DECIMAL  = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;
    localparam logic [CHAR_W-1:0]  POINT_CHAR    = 7'd46;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR  = 7'd10;
    localparam logic [CHAR_W-1:0]  ERROR_CHAR    = 7'd0;

    typedef enum logic [2:0] {
        SEL_INT,
        SEL_POINT,
        SEL_FRAC,
        SEL_NL,
        SEL_ERR
    } t_sel;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic emit;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic quot_zero;
        logic div_done;
        logic sp_one;
        logic ndig_zero;
        logic fcnt_one;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] v);
        logic [CHAR_W-1:0] wide;
        wide = {1'b0, v};
        if (v <= LAST_DECIMAL) begin
            return ZERO_CHAR + wide;
        end
        return wide + LETTER_OFFSET;
    endfunction

endpackage

// ===== hdl/rnf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the radix number formatter: division passes, digit pops,
// point, fraction steps and newline. Uses rnf_pkg.
module rnf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  rnf_pkg::t_status i_status,
    output rnf_pkg::t_cmd    o_cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DCHK,
        ST_INT_OUT,
        ST_POINT,
        ST_FRAC,
        ST_NL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_init  = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.sel       = rnf_pkg::SEL_NL;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.bad) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = rnf_pkg::SEL_ERR;
                    n_state    = ST_IDLE;
                end else if (i_status.quot_zero) begin
                    n_state = ST_POINT;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DCHK;
                end
            end
            ST_DCHK: begin
                if (i_status.quot_zero) begin
                    n_state = ST_INT_OUT;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_INT_OUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = rnf_pkg::SEL_INT;
                if (i_status.sp_one) begin
                    n_state = ST_POINT;
                end
            end
            ST_POINT: begin
                o_cmd.emit = 1'b1;
                if (i_status.ndig_zero) begin
                    o_cmd.sel = rnf_pkg::SEL_NL;
                    n_state   = ST_IDLE;
                end else begin
                    o_cmd.sel = rnf_pkg::SEL_POINT;
                    n_state   = ST_FRAC;
                end
            end
            ST_FRAC: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = rnf_pkg::SEL_FRAC;
                if (i_status.fcnt_one) begin
                    n_state = ST_NL;
                end
            end
            ST_NL: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = rnf_pkg::SEL_NL;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== hdl/rnf_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the radix number formatter: bit-serial divider, digit stack,
// fraction multiplier and character output register. Uses rnf_pkg.
module rnf_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rnf_pkg::t_cmd                        i_cmd,
    input  logic [31:0]                          i_integer_part,
    input  logic [31:0]                          i_fraction,
    input  logic [rnf_pkg::RADIX_W-1:0]          i_radix,
    input  logic [rnf_pkg::FCNT_W-1:0]           i_frac_digits,
    input  logic                                 i_is_negative,
    output rnf_pkg::t_status                     o_status,
    output logic [rnf_pkg::CHAR_W-1:0]           o_character,
    output logic                                 o_last,
    output logic                                 o_error,
    output logic                                 o_valid
);

    logic [rnf_pkg::INT_BITS-1:0]  r_quot;
    logic [rnf_pkg::RADIX_W-1:0]   r_rem;
    logic [rnf_pkg::CNT_W-1:0]     r_cnt;
    logic [rnf_pkg::FRAC_BITS-1:0] r_frac;
    logic [rnf_pkg::RADIX_W-1:0]   r_radix;
    logic [rnf_pkg::FCNT_W-1:0]    r_fcnt;
    logic                          r_bad;
    logic [rnf_pkg::SP_W-1:0]      r_sp;
    logic [rnf_pkg::RADIX_W-1:0]   r_stack [rnf_pkg::INT_BITS];
    logic [rnf_pkg::CHAR_W-1:0]    r_char;
    logic                          r_last;
    logic                          r_err;
    logic                          r_valid;

    logic [rnf_pkg::RADIX_W:0]          w_trial;
    logic                               w_ge;
    logic [rnf_pkg::RADIX_W:0]          w_rem_wide;
    logic [rnf_pkg::RADIX_W-1:0]        w_rem_next;
    logic [rnf_pkg::FRAC_BITS+5:0]      w_prod;
    logic [rnf_pkg::SP_W-1:0]           w_sp_dec;
    logic [rnf_pkg::RADIX_W-1:0]        w_top;
    logic [rnf_pkg::CHAR_W-1:0]         n_char;
    logic                               w_bad_in;

    assign w_bad_in = i_is_negative || (i_radix < rnf_pkg::LOW_RADIX)
                   || (i_radix > rnf_pkg::HIGH_RADIX)
                   || (i_frac_digits > rnf_pkg::FCNT_W'(rnf_pkg::MAX_FRAC_DIGITS));

    always_comb begin
        w_trial    = {r_rem, r_quot[rnf_pkg::INT_BITS-1]};
        w_ge       = (w_trial >= {1'b0, r_radix});
        w_rem_wide = w_ge ? (w_trial - {1'b0, r_radix}) : w_trial;
        w_rem_next = w_rem_wide[rnf_pkg::RADIX_W-1:0];
        w_prod     = {6'd0, r_frac} * {{rnf_pkg::FRAC_BITS{1'b0}}, r_radix};
        w_sp_dec   = r_sp - 1'b1;
        w_top      = r_stack[w_sp_dec[rnf_pkg::CNT_W-1:0]];
    end

    always_comb begin
        unique case (i_cmd.sel)
            rnf_pkg::SEL_INT:   n_char = rnf_pkg::digit_char(w_top);
            rnf_pkg::SEL_POINT: n_char = rnf_pkg::POINT_CHAR;
            rnf_pkg::SEL_FRAC:
                n_char = rnf_pkg::digit_char(w_prod[rnf_pkg::FRAC_BITS +: rnf_pkg::RADIX_W]);
            rnf_pkg::SEL_NL:    n_char = rnf_pkg::NEWLINE_CHAR;
            rnf_pkg::SEL_ERR:   n_char = rnf_pkg::ERROR_CHAR;
            default:            n_char = rnf_pkg::ERROR_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= i_integer_part[rnf_pkg::INT_BITS-1:0];
            r_frac  <= i_fraction[rnf_pkg::FRAC_BITS-1:0];
            r_radix <= i_radix;
            r_fcnt  <= i_frac_digits;
            r_bad   <= w_bad_in;
            r_sp    <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quot <= {r_quot[rnf_pkg::INT_BITS-2:0], w_ge};
            r_rem  <= w_rem_next;
            r_cnt  <= r_cnt + 1'b1;
            if (o_status.div_done) begin
                r_stack[r_sp[rnf_pkg::CNT_W-1:0]] <= w_rem_next;
                r_sp <= r_sp + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= (i_cmd.sel == rnf_pkg::SEL_NL) || (i_cmd.sel == rnf_pkg::SEL_ERR);
            r_err  <= (i_cmd.sel == rnf_pkg::SEL_ERR);
            if (i_cmd.sel == rnf_pkg::SEL_INT) begin
                r_sp <= w_sp_dec;
            end
            if (i_cmd.sel == rnf_pkg::SEL_FRAC) begin
                r_frac <= w_prod[rnf_pkg::FRAC_BITS-1:0];
                r_fcnt <= r_fcnt - 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_status.bad       = r_bad;
    assign o_status.quot_zero = (r_quot == '0);
    assign o_status.div_done  = (r_cnt == rnf_pkg::CNT_W'(rnf_pkg::INT_BITS - 1));
    assign o_status.sp_one    = (r_sp == rnf_pkg::SP_W'(1));
    assign o_status.ndig_zero = (r_fcnt == '0);
    assign o_status.fcnt_one  = (r_fcnt == rnf_pkg::FCNT_W'(1));

    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_error     = r_err;
    assign o_valid     = r_valid;

endmodule

// ===== hdl/radix_number_formatter.sv =====
`timescale 1ns / 1ps
// Radix number formatter top level: rnf_ctrl sequencer plus rnf_dp datapath; uses rnf_pkg.
// The first character follows the load and check states, plus one serial division pass and one
// check state per integer digit; an error result is emitted straight from the check state.
// A new item is accepted only while the sequencer is idle, once the previous item's final
// character has been issued. Characters follow back to back; no receiver stall.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
module radix_number_formatter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 i_integer_part,
    input  logic [31:0]                 i_fraction,
    input  logic [rnf_pkg::RADIX_W-1:0] i_radix,
    input  logic [rnf_pkg::FCNT_W-1:0]  i_frac_digits,
    input  logic                        i_is_negative,
    output logic                        o_valid,
    output logic [rnf_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last,
    output logic                        o_error
);

    rnf_pkg::t_cmd    w_cmd;
    rnf_pkg::t_status w_status;

    rnf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    rnf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_integer_part (i_integer_part),
        .i_fraction     (i_fraction),
        .i_radix        (i_radix),
        .i_frac_digits  (i_frac_digits),
        .i_is_negative  (i_is_negative),
        .o_status       (w_status),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_error        (o_error),
        .o_valid        (o_valid)
    );

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_valid)
        else $error("character issued without an item in flight");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside a character run");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && (o_character == rnf_pkg::ERROR_CHAR)))
        else $error("error result malformed");

    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("sequencer still busy after final character");

endmodule
